@@ hw/rtl/hws_pkg.sv @@
package hws_pkg;

    localparam int WORD_BYTES   = 7;
    localparam int BUCKET_COUNT = 256;
    localparam int WAYS         = 16;

    localparam int WORD_W      = 56;
    localparam int BUCKET_BITS = $clog2(BUCKET_COUNT);
    localparam int FILL_W      = $clog2(WAYS + 1);
    localparam int ENTRIES     = BUCKET_COUNT * WAYS;
    localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BYTE_CNT_W  = $clog2(WORD_BYTES + 1);

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [WORD_W-1:0] WORD_MASK =
        (WORD_BYTES >= 7) ? {WORD_W{1'b1}}
                          : WORD_W'((64'd1 << (8 * WORD_BYTES)) - 64'd1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

@@ hw/rtl/hashed_word_set.sv @@
// Channel | Direction | tdata (low bit up)          | tuser
// s_*     | in        | word[55:0]                  | req_type
// m_*     | out       | found, status, 6'b0 padding | -
//
// Each transaction runs in order: accept, one hash round per word byte through the
// shared 32x32 hash multiplier, the bucket fill read (S_FILL_RD, S_FILL_USE), then for
// a lookup a scan of the filled ways from the single word memory port, ending on a
// match or after the last compare, and finally the load of the output register.
// Reset clears the per-bucket valid bits, so all buckets start empty at once.
// s_tready is high only while idle; a result waits in the output register
// until taken and the block stalls before loading the next one.
module hashed_word_set
    import hws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,   // word
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // found, status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_FILL_RD,
        S_FILL_USE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic                   kind_reg;
    logic [WORD_W-1:0]      word_reg;
    logic [WORD_W-1:0]      shift_reg;
    logic [31:0]            hash_reg;
    logic [BYTE_CNT_W-1:0]  byte_cnt_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      way_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic                   pend_reg;
    logic                   last_reg;
    logic                   found_reg;
    logic                   status_reg;
    logic                   m_tvalid_reg;
    logic [7:0]             m_tdata_reg;

    logic [FILL_W-1:0]      fill_mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] fill_vld_reg;
    logic [FILL_W-1:0]      fill_rd_reg;
    logic                   vld_rd_reg;

    logic [WORD_W-1:0]      word_mem [ENTRIES];
    logic [WORD_W-1:0]      rd_word_reg;

    logic [BUCKET_BITS-1:0] bucket;
    logic [31:0]            mix;
    logic [31:0]            hash_next;
    logic [FILL_W-1:0]      fill_cur;
    logic [ADDR_W-1:0]      base_cur;
    logic                   ins_we;
    logic [ADDR_W-1:0]      mem_addr;
    logic                   match;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign bucket    = hash_reg[BUCKET_BITS-1:0];
    assign mix       = hash_reg ^ {24'd0, shift_reg[7:0]};
    assign hash_next = 32'(mix * FNV_PRIME);
    assign fill_cur  = vld_rd_reg ? fill_rd_reg : FILL_W'(0);
    assign base_cur  = ADDR_W'(ADDR_W'(bucket) * ADDR_W'(WAYS));
    assign ins_we    = (state_reg == S_FILL_USE) && (kind_reg == REQ_INSERT)
                       && (fill_cur != FILL_W'(WAYS));
    assign mem_addr  = ins_we ? ADDR_W'(base_cur + ADDR_W'(fill_cur))
                              : ADDR_W'(base_reg + ADDR_W'(way_reg));
    assign match     = (rd_word_reg == word_reg);

    always_ff @(posedge clk)
    begin
        fill_rd_reg <= fill_mem[bucket];
        if (ins_we)
        begin
            fill_mem[bucket] <= FILL_W'(fill_cur + FILL_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_vld_reg <= '0;
            vld_rd_reg   <= 1'b0;
        end
        else
        begin
            vld_rd_reg <= fill_vld_reg[bucket];
            if (ins_we)
            begin
                fill_vld_reg[bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= word_mem[mem_addr];
        if (ins_we)
        begin
            word_mem[mem_addr] <= word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg     <= s_tuser;
                        word_reg     <= s_tdata & WORD_MASK;
                        shift_reg    <= s_tdata & WORD_MASK;
                        hash_reg     <= FNV_BASIS;
                        byte_cnt_reg <= '0;
                        found_reg    <= 1'b0;
                        status_reg   <= STATUS_OK;
                        state_reg    <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    hash_reg     <= hash_next;
                    shift_reg    <= shift_reg >> 8;
                    byte_cnt_reg <= BYTE_CNT_W'(byte_cnt_reg + BYTE_CNT_W'(1));
                    if (byte_cnt_reg == BYTE_CNT_W'(WORD_BYTES - 1))
                    begin
                        state_reg <= S_FILL_RD;
                    end
                end
                S_FILL_RD:
                begin
                    state_reg <= S_FILL_USE;
                end
                S_FILL_USE:
                begin
                    fill_reg <= fill_cur;
                    base_reg <= base_cur;
                    way_reg  <= '0;
                    pend_reg <= 1'b0;
                    last_reg <= 1'b0;
                    if (kind_reg == REQ_INSERT)
                    begin
                        if (fill_cur == FILL_W'(WAYS))
                        begin
                            status_reg <= STATUS_FULL;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (fill_cur == FILL_W'(0))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // issue the next way while comparing the one read last cycle
                    pend_reg <= (way_reg < fill_reg);
                    last_reg <= (way_reg == FILL_W'(fill_reg - FILL_W'(1)));
                    way_reg  <= FILL_W'(way_reg + FILL_W'(1));
                    if (pend_reg && match)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (pend_reg && last_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, status_reg, found_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
